### rtl/core/bcc_pkg.sv
// bcc_pkg: shared types and constants for the button click classifier
// no dependencies

package bcc_pkg;

  localparam int unsigned CntW = 16;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};
  localparam logic [CntW-1:0] LONG_TICKS_RST = 16'd2000;
  localparam logic [CntW-1:0] DOUBLE_TICKS_RST = 16'd500;

  // register indexes on the configuration port
  localparam logic [0:0] REG_LONG_PRESS = 1'b0;
  localparam logic [0:0] REG_DOUBLE_CLICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } click_kind_e;

  typedef struct packed {
    logic            press_active;
    logic [CntW-1:0] held_ticks;
    logic            click_pending;
    logic [CntW-1:0] since_click_ticks;
  } bcc_state_t;

  typedef struct packed {
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] double_click_ticks;
  } bcc_cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

### rtl/core/button_click_classifier.sv
// button_click_classifier: top level, state and result registers
// depends on bcc_pkg, bcc_cfg, bcc_step
//
//  channel  | valid      | ready       | payload
//  ---------+------------+-------------+----------------------------
//  in       | in_valid_i | in_ready_o  | button_down_i
//  out      | out_valid_o| out_ready_i | click_kind_o
//  cfg      | cfg_we_i   | (none)      | cfg_idx_i, cfg_wdata_i
//
// the result is registered and appears the cycle after the item is accepted.
// a new item is taken while the result register is empty or being emptied in
// the same cycle, so a full rate stream of one item per cycle flows with no
// bubble. reset clears the tracking state and loads the default thresholds.

module button_click_classifier (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     button_down_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               click_kind_o,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [bcc_pkg::CntW-1:0] cfg_wdata_i
);

  bcc_pkg::bcc_cfg_t    cfg;
  bcc_pkg::bcc_state_t  state_q, state_d;
  bcc_pkg::click_kind_e kind_d, kind_q;
  logic                 valid_q;
  logic                 accept;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcc_step u_step (
    .button_down_i (button_down_i),
    .state_i       (state_q),
    .cfg_i         (cfg),
    .state_o       (state_d),
    .kind_o        (kind_d)
  );

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign click_kind_o = kind_q;

endmodule

### rtl/core/bcc_cfg.sv
// bcc_cfg: threshold registers written through the configuration port
// depends on bcc_pkg

module bcc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [bcc_pkg::CntW-1:0]     cfg_wdata_i,
  output bcc_pkg::bcc_cfg_t            cfg_o
);

  bcc_pkg::bcc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcc_pkg::REG_LONG_PRESS:   cfg_d.long_press_ticks = cfg_wdata_i;
        bcc_pkg::REG_DOUBLE_CLICK: cfg_d.double_click_ticks = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= bcc_pkg::LONG_TICKS_RST;
      cfg_q.double_click_ticks <= bcc_pkg::DOUBLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/bcc_step.sv
// bcc_step: per-tick next state and click classification
// depends on bcc_pkg

module bcc_step (
  input  logic                  button_down_i,
  input  bcc_pkg::bcc_state_t   state_i,
  input  bcc_pkg::bcc_cfg_t     cfg_i,
  output bcc_pkg::bcc_state_t   state_o,
  output bcc_pkg::click_kind_e  kind_o
);

  logic                     aged;
  logic                     done;
  logic [bcc_pkg::CntW-1:0] hold;
  bcc_pkg::bcc_state_t      s;

  always_comb begin
    s    = state_i;
    aged = 1'b0;
    done = 1'b0;
    kind_o = bcc_pkg::KIND_NONE;
    hold = bcc_pkg::sat_inc(state_i.held_ticks);

    if (state_i.click_pending) begin
      aged = (state_i.since_click_ticks == bcc_pkg::CNT_MAX);
      s.since_click_ticks = bcc_pkg::sat_inc(state_i.since_click_ticks);
    end

    if (button_down_i) begin
      s.press_active = 1'b1;
      s.held_ticks = state_i.press_active ? hold : '0;
    end else if (state_i.press_active) begin
      s.press_active = 1'b0;
      if (hold >= cfg_i.long_press_ticks) begin
        kind_o = bcc_pkg::KIND_LONG;
        done = 1'b1;
      end else if (s.click_pending && !aged &&
                   (s.since_click_ticks < cfg_i.double_click_ticks)) begin
        s.click_pending = 1'b0;
        kind_o = bcc_pkg::KIND_DOUBLE;
        done = 1'b1;
      end else begin
        s.click_pending = 1'b1;
        s.since_click_ticks = '0;
        aged = 1'b0;
      end
    end

    // pending click outlived the window
    if (!done && s.click_pending &&
        (aged || (s.since_click_ticks > cfg_i.double_click_ticks))) begin
      s.click_pending = 1'b0;
      kind_o = bcc_pkg::KIND_NORMAL;
    end

    state_o = s;
  end

endmodule
